### sv/path_canonicalizer_core_assert.svh
// ----------------------------------------------------------------------------
// Path canonicalizer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PATH_CANONICALIZER_CORE_ASSERT_SVH
`define PATH_CANONICALIZER_CORE_ASSERT_SVH

// Condition that must hold at every clock edge.
`define PCAN_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define PCAN_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PCAN_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/pcan_pkg.sv
// ----------------------------------------------------------------------------
// Path canonicalizer package
// Field widths, command and status codes, register indexes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package pcan_pkg;

	localparam int CMD_W     = 2;
	localparam int BYTE_W    = 8;
	localparam int IDX_W     = 8;
	localparam int STAT_W    = 2;
	localparam int LEN_W     = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_ACCEPTING = 2'd0;
	localparam logic [STAT_W-1:0] STAT_COMPLETE  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR_A      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR_B      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SEPARATOR = 2'd2;

	localparam logic [BYTE_W-1:0] RST_SEPARATOR_A      = 8'd92;
	localparam logic [BYTE_W-1:0] RST_SEPARATOR_B      = 8'd47;
	localparam logic [BYTE_W-1:0] RST_OUTPUT_SEPARATOR = 8'd47;

	localparam logic [BYTE_W-1:0] DOT_BYTE  = 8'h2E;
	localparam logic [BYTE_W-1:0] NUL_BYTE  = 8'h00;

	typedef struct packed {
		logic [BYTE_W-1:0] separator_a;
		logic [BYTE_W-1:0] separator_b;
		logic [BYTE_W-1:0] output_separator;
	} cfg_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [LEN_W-1:0]  out_length;
		logic [BYTE_W-1:0] read_data;
	} result_t;

endpackage

`default_nettype wire

### sv/pcan_in_if.sv
// ----------------------------------------------------------------------------
// Path canonicalizer command channel
// Valid/ready channel carrying one command with its byte and read index.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcan_in_if;
	logic                          valid;
	logic                          ready;
	logic [pcan_pkg::CMD_W-1:0]    command;
	logic [pcan_pkg::BYTE_W-1:0]   path_byte;
	logic [pcan_pkg::IDX_W-1:0]    read_index;

	modport source (output valid, output command, output path_byte, output read_index,
		input ready);
	modport sink (input valid, input command, input path_byte, input read_index,
		output ready);
endinterface

`default_nettype wire

### sv/pcan_out_if.sv
// ----------------------------------------------------------------------------
// Path canonicalizer result channel
// Valid/ready channel carrying status, current length and read data.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcan_out_if;
	logic                          valid;
	logic                          ready;
	logic [pcan_pkg::STAT_W-1:0]   status;
	logic [pcan_pkg::LEN_W-1:0]    out_length;
	logic [pcan_pkg::BYTE_W-1:0]   read_data;

	modport source (output valid, output status, output out_length, output read_data,
		input ready);
	modport sink (input valid, input status, input out_length, input read_data,
		output ready);
endinterface

`default_nettype wire

### sv/pcan_cfg_if.sv
// ----------------------------------------------------------------------------
// Path canonicalizer configuration channel
// Valid/ready register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcan_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pcan_pkg::CFG_IDX_W-1:0]  index;
	logic [pcan_pkg::BYTE_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/path_canonicalizer_core.sv
// ----------------------------------------------------------------------------
// Path canonicalizer core
// Builds the canonical form of a pathname pushed one byte per transaction.
//
//   Channel  Dir   Carries                                    Handshake
//   path     in    command, path_byte, read_index             valid/ready
//   result   out   status, out_length, read_data              valid/ready
//   cfg      in    index, data (separator registers)          valid/ready
//
// One transaction on path gives exactly one transaction on result.
// Clear, ignored pushes, plain byte pushes, reads at or past the length and
// the unused command go from idle to emit; a read inside the path passes the
// read state first. A ".." segment scans back over the store through the
// walk read and compare states per byte, as its one read port is registered.
// The path channel is ready only while the sequencer is idle; the result
// register lets the next command enter while a result waits to be taken.
// Reset is asynchronous; the line store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module path_canonicalizer_core #(
	parameter int BUFFER_DEPTH = 256
) (
	input wire logic clk,
	input wire logic arst_n,
	pcan_in_if.sink      path,
	pcan_out_if.source   result,
	pcan_cfg_if.sink     cfg
);

	pcan_pkg::cfg_t     cfg_q;
	pcan_pkg::result_t  res;
	pcan_pkg::result_t  res_q;
	logic               res_valid;
	logic               out_valid_q;
	logic               slot_free;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.separator_a      <= pcan_pkg::RST_SEPARATOR_A;
			cfg_q.separator_b      <= pcan_pkg::RST_SEPARATOR_B;
			cfg_q.output_separator <= pcan_pkg::RST_OUTPUT_SEPARATOR;
		end else if (cfg.valid) begin
			case (cfg.index)
				pcan_pkg::REG_SEPARATOR_A:      cfg_q.separator_a      <= cfg.data;
				pcan_pkg::REG_SEPARATOR_B:      cfg_q.separator_b      <= cfg.data;
				pcan_pkg::REG_OUTPUT_SEPARATOR: cfg_q.output_separator <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	pcan_ctrl #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.path      (path),
		.slot_free (slot_free),
		.res_valid (res_valid),
		.res       (res)
	);

	// The result register may be refilled in the cycle it is drained.
	assign slot_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.status     = res_q.status;
	assign result.out_length = res_q.out_length;
	assign result.read_data  = res_q.read_data;

endmodule

`default_nettype wire

### sv/pcan_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pcan_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### sv/pcan_ctrl.sv
// ----------------------------------------------------------------------------
// Path canonicalizer sequencer
// Parser state machine, write pointer and the walk-back loop over the store.
// ----------------------------------------------------------------------------
`default_nettype none
`include "path_canonicalizer_core_assert.svh"

module pcan_ctrl #(
	parameter int BUFFER_DEPTH = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pcan_pkg::cfg_t   cfg,
	pcan_in_if.sink               path,
	input  wire logic             slot_free,
	output logic                  res_valid,
	output pcan_pkg::result_t     res
);

	localparam int AW   = $clog2(BUFFER_DEPTH);
	localparam int WPW  = $clog2(BUFFER_DEPTH + 1);
	localparam int CMPW = WPW + pcan_pkg::IDX_W;
	localparam logic [WPW-1:0] DEPTH_WP = WPW'(BUFFER_DEPTH);

	// Sequencer states.
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_READ     = 3'd1;
	localparam logic [2:0] ST_WALK_RD  = 3'd2;
	localparam logic [2:0] ST_WALK_CMP = 3'd3;
	localparam logic [2:0] ST_EMIT     = 3'd4;

	// Parser states.
	localparam logic [2:0] PS_START     = 3'd0;
	localparam logic [2:0] PS_SEPARATOR = 3'd1;
	localparam logic [2:0] PS_NORMAL    = 3'd2;
	localparam logic [2:0] PS_DOT1      = 3'd3;
	localparam logic [2:0] PS_DOT2      = 3'd4;

	logic [2:0]                    state_q, state_d;
	logic [2:0]                    ps_q, ps_d;
	logic [WPW-1:0]                wp_q, wp_d;
	logic [pcan_pkg::STAT_W-1:0]   fin_q, fin_d;
	logic                          zero_q, zero_d;
	logic [pcan_pkg::BYTE_W-1:0]   data_q, data_d;

	logic                          we;
	logic [pcan_pkg::BYTE_W-1:0]   wdata;
	logic [AW-1:0]                 raddr;
	logic [pcan_pkg::BYTE_W-1:0]   rdata;

	logic                          b_zero, b_sep, b_dot, read_hit, accept;

	assign b_zero   = (path.path_byte == pcan_pkg::NUL_BYTE);
	assign b_sep    = (path.path_byte == cfg.separator_a) ||
		(path.path_byte == cfg.separator_b);
	assign b_dot    = (path.path_byte == pcan_pkg::DOT_BYTE);
	assign read_hit = CMPW'(path.read_index) < CMPW'(wp_q);
	assign accept   = path.valid && path.ready;

	assign path.ready = (state_q == ST_IDLE);

	pcan_ram #(
		.WIDTH (pcan_pkg::BYTE_W),
		.DEPTH (BUFFER_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (AW'(wp_q)),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		state_d   = state_q;
		ps_d      = ps_q;
		wp_d      = wp_q;
		fin_d     = fin_q;
		zero_d    = zero_q;
		data_d    = data_q;
		we        = 1'b0;
		wdata     = path.path_byte;
		raddr     = AW'(wp_q - 1'b1);
		res_valid = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (path.valid) begin
					data_d  = '0;
					state_d = ST_EMIT;
					case (path.command)
						pcan_pkg::CMD_CLEAR: begin
							wp_d  = '0;
							ps_d  = PS_START;
							fin_d = pcan_pkg::STAT_ACCEPTING;
						end
						pcan_pkg::CMD_PUSH: begin
							if (fin_q == pcan_pkg::STAT_ACCEPTING) begin
								if (wp_q >= DEPTH_WP) begin
									fin_d = pcan_pkg::STAT_OVERFLOW;
								end else begin
									case (ps_q)
										PS_SEPARATOR: begin
											if (b_zero) begin
												fin_d = pcan_pkg::STAT_COMPLETE;
											end else if (!b_sep) begin
												ps_d = b_dot ? PS_DOT1 : PS_NORMAL;
												we   = 1'b1;
												wp_d = wp_q + 1'b1;
											end
										end
										PS_NORMAL: begin
											if (b_zero) begin
												fin_d = pcan_pkg::STAT_COMPLETE;
											end else if (b_sep) begin
												ps_d  = PS_SEPARATOR;
												we    = 1'b1;
												wdata = cfg.output_separator;
												wp_d  = wp_q + 1'b1;
											end else begin
												we   = 1'b1;
												wp_d = wp_q + 1'b1;
											end
										end
										PS_DOT1: begin
											if (b_zero || b_sep) begin
												// Drop the lone dot that was stored.
												if (wp_q != '0) begin
													wp_d = wp_q - 1'b1;
												end
												if (b_zero) begin
													fin_d = pcan_pkg::STAT_COMPLETE;
												end else begin
													ps_d = PS_SEPARATOR;
												end
											end else begin
												ps_d = b_dot ? PS_DOT2 : PS_NORMAL;
												we   = 1'b1;
												wp_d = wp_q + 1'b1;
											end
										end
										PS_DOT2: begin
											if (b_zero || b_sep) begin
												// Remove the two dots; a longer path also loses the separator
												// before them and then scans back to the previous output
												// separator.
												ps_d   = PS_SEPARATOR;
												zero_d = b_zero;
												if (wp_q < WPW'(2)) begin
													wp_d = '0;
													if (b_zero) begin
														fin_d = pcan_pkg::STAT_COMPLETE;
													end
												end else if (wp_q < WPW'(4)) begin
													wp_d = wp_q - WPW'(2);
													if (b_zero) begin
														fin_d = pcan_pkg::STAT_COMPLETE;
													end
												end else begin
													wp_d    = wp_q - WPW'(3);
													state_d = ST_WALK_RD;
												end
											end else begin
												ps_d = PS_NORMAL;
												we   = 1'b1;
												wp_d = wp_q + 1'b1;
											end
										end
										default: begin
											if (b_zero) begin
												fin_d = pcan_pkg::STAT_COMPLETE;
											end else if (b_sep) begin
												ps_d  = PS_SEPARATOR;
												we    = 1'b1;
												wdata = cfg.output_separator;
												wp_d  = wp_q + 1'b1;
											end else begin
												ps_d = b_dot ? PS_DOT1 : PS_NORMAL;
												we   = 1'b1;
												wp_d = wp_q + 1'b1;
											end
										end
									endcase
								end
							end
						end
						pcan_pkg::CMD_READ: begin
							raddr = AW'(path.read_index);
							if (read_hit) begin
								state_d = ST_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_READ: begin
				data_d  = rdata;
				state_d = ST_EMIT;
			end
			ST_WALK_RD: begin
				if (wp_q == '0) begin
					if (zero_q) begin
						fin_d = pcan_pkg::STAT_COMPLETE;
					end
					state_d = ST_EMIT;
				end else begin
					state_d = ST_WALK_CMP;
				end
			end
			ST_WALK_CMP: begin
				if (rdata == cfg.output_separator) begin
					if (zero_q) begin
						fin_d = pcan_pkg::STAT_COMPLETE;
					end
					state_d = ST_EMIT;
				end else begin
					wp_d    = wp_q - 1'b1;
					state_d = ST_WALK_RD;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					res_valid = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ps_q    <= PS_START;
			wp_q    <= '0;
			fin_q   <= pcan_pkg::STAT_ACCEPTING;
			zero_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			ps_q    <= ps_d;
			wp_q    <= wp_d;
			fin_q   <= fin_d;
			zero_q  <= zero_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign res.status     = fin_q;
	assign res.out_length = pcan_pkg::LEN_W'(wp_q);
	assign res.read_data  = data_q;

	`PCAN_ASSERT_ALWAYS(a_wp_bound, wp_q <= DEPTH_WP, "write pointer beyond store depth")
	`PCAN_ASSERT_NEXT(a_push_after_finish, accept && path.command == pcan_pkg::CMD_PUSH && fin_q != pcan_pkg::STAT_ACCEPTING, $stable(wp_q) && $stable(fin_q), "push after finish changed state")
	`PCAN_ASSERT_NEXT(a_clear, accept && path.command == pcan_pkg::CMD_CLEAR, wp_q == '0 && fin_q == pcan_pkg::STAT_ACCEPTING && ps_q == PS_START, "clear did not restart the path")
	`PCAN_ASSERT_SAME(a_walk_addr, state_q == ST_WALK_CMP, wp_q != '0, "walk-back compare without a byte before the pointer")

endmodule

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// Path canonicalizer core testbench
// Drives command transactions into the core and keeps a software copy of the
// line store and parser. Each expected result is checked field by field. The
// run starts with directed paths and moves through several separator
// settings, from the reset values to both ends of the byte range. Most of the
// random stimulus is well-formed paths with dot segments and separator runs.
// Random stalls on both channels are used everywhere except in the last phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import pcan_pkg::*;

	localparam int BUFFER_DEPTH = 256;
	localparam int PHASE_ITEMS  = 258;
	localparam int CYCLE_LIMIT  = 4000000;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		PS_START, PS_SEPARATOR, PS_NORMAL, PS_DOT1, PS_DOT2
	} parse_state_e;

	// Tracks the canonical path as the core should build it and queues the
	// result that every accepted command must produce.
	class canon_path_tracker;
		logic [BYTE_W-1:0] separator_a;
		logic [BYTE_W-1:0] separator_b;
		logic [BYTE_W-1:0] output_separator;
		logic [BYTE_W-1:0] line_store [BUFFER_DEPTH];
		int unsigned       write_position;
		parse_state_e      parse_state;
		logic [STAT_W-1:0] finish_status;
		result_t           pending_results [$];
		int unsigned       mismatches;

		function new();
			separator_a      = RST_SEPARATOR_A;
			separator_b      = RST_SEPARATOR_B;
			output_separator = RST_OUTPUT_SEPARATOR;
			write_position   = 0;
			parse_state      = PS_START;
			finish_status    = STAT_ACCEPTING;
			mismatches       = 0;
		endfunction

		function bit is_separator(logic [BYTE_W-1:0] b);
			return b == separator_a || b == separator_b;
		endfunction

		function void store_byte(logic [BYTE_W-1:0] b);
			if (write_position < BUFFER_DEPTH) begin
				line_store[write_position] = b;
				write_position++;
			end
		endfunction

		// Drops the ".." just stored, then steps back to just after the
		// previous output separator.
		function void walk_back();
			if (write_position < 2) begin
				write_position = 0;
				return;
			end
			write_position -= 2;
			if (write_position < 2)
				return;
			do
				write_position--;
			while (write_position > 0 &&
				line_store[write_position - 1] != output_separator);
		endfunction

		function void push_byte(logic [BYTE_W-1:0] b);
			while (1) begin
				if (write_position >= BUFFER_DEPTH) begin
					finish_status = STAT_OVERFLOW;
					return;
				end
				case (parse_state)
					PS_START: begin
						if (b == NUL_BYTE) begin
							finish_status = STAT_COMPLETE;
							return;
						end
						parse_state = PS_SEPARATOR;
						if (is_separator(b)) begin
							store_byte(output_separator);
							return;
						end
					end
					PS_SEPARATOR: begin
						if (b == NUL_BYTE) begin
							finish_status = STAT_COMPLETE;
							return;
						end
						if (is_separator(b))
							return;
						parse_state = (b == DOT_BYTE) ? PS_DOT1 : PS_NORMAL;
						store_byte(b);
						return;
					end
					PS_NORMAL: begin
						if (b == NUL_BYTE) begin
							finish_status = STAT_COMPLETE;
							return;
						end
						if (is_separator(b)) begin
							parse_state = PS_SEPARATOR;
							store_byte(output_separator);
							return;
						end
						store_byte(b);
						return;
					end
					PS_DOT1: begin
						if (b == NUL_BYTE || is_separator(b)) begin
							if (write_position > 0)
								write_position--;
							if (b == NUL_BYTE)
								finish_status = STAT_COMPLETE;
							else
								parse_state = PS_SEPARATOR;
							return;
						end
						parse_state = (b == DOT_BYTE) ? PS_DOT2 : PS_NORMAL;
						store_byte(b);
						return;
					end
					PS_DOT2: begin
						if (b == NUL_BYTE || is_separator(b)) begin
							// The byte is handled again from the separator state.
							walk_back();
							parse_state = PS_SEPARATOR;
						end else begin
							parse_state = PS_NORMAL;
							store_byte(b);
							return;
						end
					end
					default: parse_state = PS_START;
				endcase
			end
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] index, logic [BYTE_W-1:0] value);
			case (index)
				REG_SEPARATOR_A:      separator_a = value;
				REG_SEPARATOR_B:      separator_b = value;
				REG_OUTPUT_SEPARATOR: output_separator = value;
				default: ;
			endcase
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b,
			logic [IDX_W-1:0] idx);
			result_t           expected;
			logic [BYTE_W-1:0] data;
			data = '0;
			case (cmd)
				CMD_CLEAR: begin
					write_position = 0;
					parse_state    = PS_START;
					finish_status  = STAT_ACCEPTING;
				end
				CMD_PUSH: begin
					if (finish_status == STAT_ACCEPTING)
						push_byte(b);
				end
				CMD_READ: begin
					if (idx < write_position)
						data = line_store[idx];
				end
				default: ;
			endcase
			expected.status     = finish_status;
			expected.out_length = LEN_W'(write_position);
			expected.read_data  = data;
			pending_results.push_back(expected);
		endfunction

		function void check_result(result_t actual);
			result_t expected;
			if (pending_results.size() == 0) begin
				$error("result transaction with no expected result pending");
				mismatches++;
				return;
			end
			expected = pending_results.pop_front();
			if (actual.status !== expected.status) begin
				$error("status: expected %0d, actual %0d", expected.status, actual.status);
				mismatches++;
			end
			if (actual.out_length !== expected.out_length) begin
				$error("out_length: expected %0d, actual %0d",
					expected.out_length, actual.out_length);
				mismatches++;
			end
			if (actual.read_data !== expected.read_data) begin
				$error("read_data: expected 0x%02h, actual 0x%02h",
					expected.read_data, actual.read_data);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pcan_in_if  path_ch ();
	pcan_out_if result_ch ();
	pcan_cfg_if cfg_ch ();

	path_canonicalizer_core #(
		.BUFFER_DEPTH(BUFFER_DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.path   (path_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	canon_path_tracker tracker = new();

	bit          calm;
	int          stall_left;
	int unsigned sent_items;
	int unsigned cycle_count;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: check every transaction and stall ready in random bursts.
	always @(posedge clk) begin
		result_t observed;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			observed.status     = result_ch.status;
			observed.out_length = result_ch.out_length;
			observed.read_data  = result_ch.read_data;
			tracker.check_result(observed);
		end
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else if (!calm && stall_left > 0) begin
			stall_left--;
			result_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 8);
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	// Valid stays high from one transaction to the next unless a gap is taken.
	task automatic send_command(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b,
		logic [IDX_W-1:0] idx);
		bit ignored;
		if (!calm && $urandom_range(0, 5) == 0) begin
			path_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		path_ch.valid      <= 1'b1;
		path_ch.command    <= cmd;
		path_ch.path_byte  <= b;
		path_ch.read_index <= idx;
		do
			@(posedge clk);
		while (!path_ch.ready);
		ignored = cmd == CMD_PUSH && tracker.finish_status != STAT_ACCEPTING;
		tracker.note_command(cmd, b, idx);
		if (!ignored)
			sent_items++;
	endtask

	task automatic wait_for_results();
		path_ch.valid <= 1'b0;
		while (tracker.pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [BYTE_W-1:0] rand_byte();
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	task automatic set_separators(logic [BYTE_W-1:0] sep_a, logic [BYTE_W-1:0] sep_b,
		logic [BYTE_W-1:0] out_sep);
		logic [CFG_IDX_W-1:0] regs [3];
		logic [BYTE_W-1:0]    values [3];
		regs   = '{REG_SEPARATOR_A, REG_SEPARATOR_B, REG_OUTPUT_SEPARATOR};
		values = '{sep_a, sep_b, out_sep};
		for (int r = 0; r < 3; r++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.index <= regs[r];
			cfg_ch.data  <= values[r];
			do
				@(posedge clk);
			while (!cfg_ch.ready);
			tracker.write_register(regs[r], values[r]);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_command(CMD_PUSH, s[i], rand_byte());
	endtask

	function automatic logic [BYTE_W-1:0] plain_byte();
		logic [BYTE_W-1:0] b;
		do begin
			if ($urandom_range(0, 3) == 0)
				b = BYTE_W'($urandom_range(1, 255));
			else
				b = BYTE_W'($urandom_range(8'h61, 8'h7A));
		end while (tracker.is_separator(b) || b == DOT_BYTE);
		return b;
	endfunction

	function automatic logic [BYTE_W-1:0] name_byte();
		case ($urandom_range(0, 7))
			0:       return DOT_BYTE;
			1:       return BYTE_W'($urandom_range(1, 255));
			default: return BYTE_W'($urandom_range(8'h61, 8'h7A));
		endcase
	endfunction

	task automatic send_separator_run();
		int n;
		n = $urandom_range(1, 3);
		repeat (n)
			send_command(CMD_PUSH, $urandom_range(0, 1) ? tracker.separator_a :
				tracker.separator_b, rand_byte());
	endtask

	task automatic send_reads(int n);
		int unsigned len;
		repeat (n) begin
			len = tracker.write_position;
			if (len > 0 && $urandom_range(0, 3) != 0)
				send_command(CMD_READ, rand_byte(),
					IDX_W'($urandom_range(0, (len > 256 ? 256 : len) - 1)));
			else
				send_command(CMD_READ, rand_byte(), rand_byte());
		end
	endtask

	task automatic send_random_path();
		int segments;
		send_command(CMD_CLEAR, rand_byte(), rand_byte());
		if ($urandom_range(0, 1))
			send_separator_run();
		segments = $urandom_range(0, 7);
		for (int s = 0; s < segments; s++) begin
			case ($urandom_range(0, 5))
				0: send_text(".");
				1: send_text("..");
				2, 3: begin
					repeat ($urandom_range(1, 6))
						send_command(CMD_PUSH, name_byte(), rand_byte());
				end
				4: begin
					// Names that start with dots but are not dot segments.
					send_command(CMD_PUSH, DOT_BYTE, rand_byte());
					if ($urandom_range(0, 1))
						send_command(CMD_PUSH, DOT_BYTE, rand_byte());
					send_command(CMD_PUSH, plain_byte(), rand_byte());
				end
				default: send_command(CMD_PUSH, rand_byte(), rand_byte());
			endcase
			if ($urandom_range(0, 4) != 0)
				send_separator_run();
		end
		if ($urandom_range(0, 9) != 0)
			send_command(CMD_PUSH, NUL_BYTE, rand_byte());
		if ($urandom_range(0, 5) == 0)
			send_command(CMD_PUSH, rand_byte(), rand_byte());
		send_reads($urandom_range(0, 3));
	endtask

	// Fills the whole store with one component, then pushes once more and reads the last and first bytes.
	task automatic send_full_store(bit end_with_zero);
		send_command(CMD_CLEAR, rand_byte(), rand_byte());
		repeat (BUFFER_DEPTH)
			send_command(CMD_PUSH, plain_byte(), rand_byte());
		send_command(CMD_PUSH, end_with_zero ? NUL_BYTE : plain_byte(), rand_byte());
		send_command(CMD_READ, rand_byte(), 8'd255);
		send_command(CMD_READ, rand_byte(), 8'd0);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 4))
			send_command(CMD_W'($urandom_range(0, 3)), rand_byte(), rand_byte());
	endtask

	initial begin
		int unsigned phase_end;
		int          paths;
		arst_n             = 1'b0;
		calm               = 1'b0;
		stall_left         = 0;
		sent_items         = 0;
		cycle_count        = 0;
		path_ch.valid      = 1'b0;
		path_ch.command    = CMD_CLEAR;
		path_ch.path_byte  = '0;
		path_ch.read_index = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = REG_SEPARATOR_A;
		cfg_ch.data        = '0;
		result_ch.ready    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Empty path, then a push after the path has finished.
		send_command(CMD_CLEAR, 8'hFF, 8'hFF);
		send_command(CMD_PUSH, NUL_BYTE, 8'h00);
		send_command(CMD_PUSH, 8'h61, 8'h00);
		// Mixed separator run, a dropped dot and a double dot back to the root.
		send_command(CMD_CLEAR, 8'h00, 8'h00);
		send_text("\\/x/./..");
		send_command(CMD_PUSH, NUL_BYTE, 8'hFF);
		send_command(CMD_READ, 8'h00, 8'd0);
		send_command(CMD_READ, 8'h00, 8'd200);
		send_command(CMD_UNUSED, 8'hFF, 8'hFF);
		// Trailing dot.
		send_command(CMD_CLEAR, 8'h00, 8'h00);
		send_text("a/.");
		send_command(CMD_PUSH, NUL_BYTE, 8'h00);
		// Double dot with nothing before it.
		send_command(CMD_CLEAR, 8'h00, 8'h00);
		send_text("..");
		send_command(CMD_PUSH, NUL_BYTE, 8'h00);
		send_command(CMD_READ, 8'hFF, 8'd0);

		for (int phase = 0; phase < 6; phase++) begin
			if (phase > 0) begin
				wait_for_results();
				case (phase)
					1: set_separators(8'h00, 8'hFF, 8'h00);
					2: set_separators(8'hFF, DOT_BYTE, 8'hFF);
					3: set_separators(8'h2F, 8'h2F, 8'h5C);
					4: set_separators(rand_byte(), rand_byte(), rand_byte());
					default: set_separators(RST_SEPARATOR_A, RST_SEPARATOR_B,
						RST_OUTPUT_SEPARATOR);
				endcase
			end
			calm      = (phase == 5);
			phase_end = sent_items + PHASE_ITEMS;
			if (phase == 1 || phase == 4)
				send_full_store(phase == 1);
			paths = 0;
			while (sent_items < phase_end) begin
				// Now and then hold off until the core has answered everything.
				if (paths % 9 == 8)
					wait_for_results();
				if ($urandom_range(0, 9) == 0)
					send_noise();
				else
					send_random_path();
				paths++;
			end
		end

		wait_for_results();
		repeat (20) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
